[rtl/core/ookrft_pkg.sv]
// Shared types and constants for the OOK remote frame transmitter.
// Holds operation codes, register indexes, frame field positions and pulse lengths.
// No dependencies.
package ookrft_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ONOFF = 2'd1,
    OP_DIM   = 2'd2
  } op_t;

  localparam logic REG_HOUSE_CODE  = 1'b0;
  localparam logic REG_UNIT_PERIOD = 1'b1;

  localparam int HOUSE_W   = 26;
  localparam int PERIOD_W  = 10;
  localparam int FIELD_W   = 6;
  localparam int LOW_W     = 6;
  localparam int NIBBLE_W  = 4;
  localparam int CFG_ADDR_W = 3;

  localparam logic [HOUSE_W-1:0]  HOUSE_CODE_RST  = 26'h308CC14;
  localparam logic [PERIOD_W-1:0] UNIT_PERIOD_RST = 10'd249;

  localparam logic [FIELD_W-1:0] FIELD_START   = 6'd0;
  localparam logic [FIELD_W-1:0] FIELD_HOUSE_L = 6'd26;
  localparam logic [FIELD_W-1:0] FIELD_GROUP   = 6'd27;
  localparam logic [FIELD_W-1:0] FIELD_MARK    = 6'd28;
  localparam logic [FIELD_W-1:0] FIELD_CHAN_L  = 6'd32;
  localparam logic [FIELD_W-1:0] FIELD_LEVEL_L = 6'd36;
  localparam logic [FIELD_W-1:0] STOP_ONOFF    = 6'd33;
  localparam logic [FIELD_W-1:0] STOP_DIM      = 6'd37;

  localparam logic [LOW_W-1:0] LOW_SHORT     = 6'd1;
  localparam logic [LOW_W-1:0] LOW_LONG      = 6'd5;
  localparam logic [LOW_W-1:0] LOW_START     = 6'd10;
  localparam logic [LOW_W-1:0] LOW_STOP      = 6'd40;
  localparam logic [LOW_W-1:0] LOW_STOP_DIM  = 6'd60;

  typedef struct packed {
    logic [FIELD_W-1:0]  field_index;
    logic                half_phase;
    logic                is_dim;
    logic                on_off;
    logic [NIBBLE_W-1:0] channel;
    logic [NIBBLE_W-1:0] dim_level;
  } pulse_pos_t;

endpackage

[rtl/core/ookrft_low_len.sv]
// Low-time lookup for the pulse at the current frame position.
// Maps field index, pulse half and held command values to a count of low units.
// Depends on ookrft_pkg.
module ookrft_low_len (
  input  ookrft_pkg::pulse_pos_t                 pos,
  input  logic [ookrft_pkg::HOUSE_W-1:0]         house_code,
  output logic [ookrft_pkg::LOW_W-1:0]           low_len
);
  import ookrft_pkg::*;

  logic [FIELD_W-1:0] stop_field;
  logic [FIELD_W-1:0] house_idx;
  logic [FIELD_W-1:0] chan_idx;
  logic [FIELD_W-1:0] level_idx;
  logic               data_bit;
  logic [LOW_W-1:0]   bit_len;

  assign stop_field = pos.is_dim ? STOP_DIM : STOP_ONOFF;
  assign house_idx  = FIELD_HOUSE_L - pos.field_index;
  assign chan_idx   = FIELD_CHAN_L - pos.field_index;
  assign level_idx  = FIELD_LEVEL_L - pos.field_index;

  always_comb begin
    priority if (pos.field_index <= FIELD_HOUSE_L) begin
      data_bit = ~house_code[house_idx[4:0]];
    end else if (pos.field_index == FIELD_GROUP) begin
      data_bit = 1'b0;
    end else if (pos.field_index == FIELD_MARK) begin
      data_bit = pos.on_off;
    end else if (pos.field_index < STOP_ONOFF) begin
      data_bit = ~pos.channel[chan_idx[1:0]];
    end else begin
      data_bit = ~pos.dim_level[level_idx[1:0]];
    end
  end

  assign bit_len = (data_bit ^ pos.half_phase) ? LOW_LONG : LOW_SHORT;

  always_comb begin
    priority if (pos.field_index == FIELD_START) begin
      low_len = LOW_START;
    end else if (pos.field_index >= stop_field) begin
      low_len = pos.is_dim ? LOW_STOP_DIM : LOW_STOP;
    end else if (pos.field_index == FIELD_MARK && pos.is_dim) begin
      low_len = LOW_SHORT;
    end else begin
      low_len = bit_len;
    end
  end

endmodule

[rtl/core/ook_remote_frame_transmitter.sv]
// OOK remote frame transmitter top level.
// Instantiates ookrft_low_len; depends on ookrft_pkg.
//
// Usage: every input beat is either a time tick or a send command. A command
// latches the channel, on/off bit or dim level and a burst count, then the
// block plays that many frames, one step per tick, on the transmitter pin.
// Each input beat yields exactly one output beat carrying the pin level, the
// busy flag and a flag that marks a command dropped because frames were still
// being played. The house code and unit period registers are written through
// the APB port and read back at byte addresses 0 and 4.
// The output beat follows its input beat in the next cycle, and a new beat
// is taken in every cycle while the output is not stalled, since the state
// update is a single counter step plus a lookup of the next pulse length.
// The output beat sits in a register; while it is stalled the input side is
// stalled as well, so nothing is lost or repeated.
// Reset leaves the block idle with the line state low and restores the register
// defaults; the pin level, busy and rejected output registers are not reset.
module ook_remote_frame_transmitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_operation,
  input  logic [ookrft_pkg::NIBBLE_W-1:0]     in_channel,
  input  logic                                in_on_off,
  input  logic [ookrft_pkg::NIBBLE_W-1:0]     in_dim_level,
  input  logic [ookrft_pkg::NIBBLE_W-1:0]     in_bursts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pin_level,
  output logic                                out_busy_res,
  output logic                                out_rejected,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ookrft_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ookrft_pkg::*;

  logic [HOUSE_W-1:0]  house_code_r;
  logic [PERIOD_W-1:0] unit_period_r;

  logic                line_r, line_nxt;
  logic [PERIOD_W-1:0] tick_r, tick_nxt;
  logic [LOW_W-1:0]    low_r, low_nxt;
  logic [FIELD_W-1:0]  field_r, field_nxt;
  logic                half_r, half_nxt;
  logic [NIBBLE_W-1:0] bursts_r, bursts_nxt;
  logic [NIBBLE_W-1:0] chan_r, chan_nxt;
  logic                on_off_r, on_off_nxt;
  logic [NIBBLE_W-1:0] level_r, level_nxt;
  logic                is_dim_r, is_dim_nxt;
  logic                active_r, active_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                pin_r, pin_nxt;
  logic                busy_r, busy_nxt;
  logic                rej_r, rej_nxt;

  logic                in_acc;
  logic                cfg_wr;
  logic [PERIOD_W-1:0] tick_inc;
  logic [LOW_W-1:0]    low_dec;
  logic [NIBBLE_W-1:0] bursts_dec;
  logic [FIELD_W-1:0]  stop_field;
  logic [LOW_W-1:0]    low_len;
  pulse_pos_t          pos;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_pin_level = pin_r;
  assign out_busy_res  = busy_r;
  assign out_rejected  = rej_r;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_HOUSE_CODE:  prdata = {{(32-HOUSE_W){1'b0}}, house_code_r};
      REG_UNIT_PERIOD: prdata = {{(32-PERIOD_W){1'b0}}, unit_period_r};
      default:         prdata = '0;
    endcase
  end

  assign pos.field_index = field_r;
  assign pos.half_phase  = half_r;
  assign pos.is_dim      = is_dim_r;
  assign pos.on_off      = on_off_r;
  assign pos.channel     = chan_r;
  assign pos.dim_level   = level_r;

  ookrft_low_len u_low_len (
    .pos        (pos),
    .house_code (house_code_r),
    .low_len    (low_len)
  );

  assign tick_inc   = tick_r + PERIOD_W'(1);
  assign low_dec    = low_r - LOW_W'(1);
  assign bursts_dec = bursts_r - NIBBLE_W'(1);
  assign stop_field = is_dim_r ? STOP_DIM : STOP_ONOFF;

  always_comb begin
    line_nxt   = line_r;
    tick_nxt   = tick_r;
    low_nxt    = low_r;
    field_nxt  = field_r;
    half_nxt   = half_r;
    bursts_nxt = bursts_r;
    chan_nxt   = chan_r;
    on_off_nxt = on_off_r;
    level_nxt  = level_r;
    is_dim_nxt = is_dim_r;
    active_nxt = active_r;
    pin_nxt    = line_r;
    busy_nxt   = active_r;
    rej_nxt    = 1'b0;

    if (in_acc) begin
      unique case (op_t'(in_operation))
        OP_TICK: begin
          if (active_r) begin
            if (tick_inc >= unit_period_r) begin
              tick_nxt = '0;
              if (line_r) begin
                line_nxt = 1'b0;
                low_nxt  = low_len;
              end else begin
                low_nxt = low_dec;
                if (low_dec == '0) begin
                  line_nxt = 1'b1;
                  if (field_r >= stop_field) begin
                    field_nxt  = FIELD_START;
                    half_nxt   = 1'b0;
                    bursts_nxt = bursts_dec;
                    if (bursts_dec == '0) begin
                      active_nxt = 1'b0;
                      line_nxt   = 1'b0;
                    end
                  end else if (field_r == FIELD_START || half_r) begin
                    field_nxt = field_r + FIELD_W'(1);
                    half_nxt  = 1'b0;
                  end else begin
                    half_nxt = 1'b1;
                  end
                end
              end
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
        OP_ONOFF, OP_DIM: begin
          if (active_r) begin
            rej_nxt = 1'b1;
          end else begin
            is_dim_nxt = (op_t'(in_operation) == OP_DIM);
            chan_nxt   = in_channel;
            on_off_nxt = in_on_off;
            level_nxt  = in_dim_level;
            bursts_nxt = in_bursts;
            if (in_bursts != '0) begin
              active_nxt = 1'b1;
              line_nxt   = 1'b1;
              tick_nxt   = '0;
              low_nxt    = '0;
              field_nxt  = FIELD_START;
              half_nxt   = 1'b0;
            end
          end
          pin_nxt  = line_nxt;
          busy_nxt = active_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      house_code_r  <= HOUSE_CODE_RST;
      unit_period_r <= UNIT_PERIOD_RST;
      line_r        <= 1'b0;
      tick_r        <= '0;
      low_r         <= '0;
      field_r       <= '0;
      half_r        <= 1'b0;
      bursts_r      <= '0;
      chan_r        <= '0;
      on_off_r      <= 1'b0;
      level_r       <= '0;
      is_dim_r      <= 1'b0;
      active_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_HOUSE_CODE:  house_code_r  <= pwdata[HOUSE_W-1:0];
          REG_UNIT_PERIOD: unit_period_r <= pwdata[PERIOD_W-1:0];
          default: begin
          end
        endcase
      end
      line_r      <= line_nxt;
      tick_r      <= tick_nxt;
      low_r       <= low_nxt;
      field_r     <= field_nxt;
      half_r      <= half_nxt;
      bursts_r    <= bursts_nxt;
      chan_r      <= chan_nxt;
      on_off_r    <= on_off_nxt;
      level_r     <= level_nxt;
      is_dim_r    <= is_dim_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pin_r  <= pin_nxt;
      busy_r <= busy_nxt;
      rej_r  <= rej_nxt;
    end
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for ook_remote_frame_transmitter: a directed table and then random command
// and tick beats, each checked against a table value or a cycle-free model of the frame sequencer.
// Depends on ookrft_pkg and the transmitter RTL only.
module tb_top;
  import ookrft_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int FRAME_UNITS_ONOFF = 308;
  localparam int FRAME_UNITS_DIM = 356;
  localparam int RANDOM_TARGET = 1150;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int END_WAIT = 4;
  localparam int PLAN_ROWS = 25;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic rejected;
  } pin_report_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [NIBBLE_W-1:0] channel;
    logic on_off;
    logic [NIBBLE_W-1:0] dim_level;
    logic [NIBBLE_W-1:0] bursts;
  } beat_t;

  typedef struct packed {
    logic typed;
    pin_report_t want;
  } typed_entry_t;

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    beat_t beat;
    logic typed;
    pin_report_t want;
    logic reg_idx;
    logic [31:0] value;
  } plan_row_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_COMB, STALL_HEAVY} stall_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [NIBBLE_W-1:0] in_channel = '0;
  logic in_on_off = 1'b0;
  logic [NIBBLE_W-1:0] in_dim_level = '0;
  logic [NIBBLE_W-1:0] in_bursts = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_pin_level;
  logic out_busy_res;
  logic out_rejected;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Model state of the frame sequencer and its registers.
  logic [HOUSE_W-1:0] house_q = HOUSE_CODE_RST;
  logic [PERIOD_W-1:0] period_q = UNIT_PERIOD_RST;
  logic line_lvl = 1'b0;
  logic [PERIOD_W-1:0] tick_cnt = '0;
  logic [LOW_W-1:0] low_left = '0;
  logic [FIELD_W-1:0] field_pos = '0;
  logic half_sel = 1'b0;
  logic [NIBBLE_W-1:0] frames_left = '0;
  logic [NIBBLE_W-1:0] ch_q = '0;
  logic onoff_q = 1'b0;
  logic [NIBBLE_W-1:0] dim_q = '0;
  logic dim_sel = 1'b0;
  logic playing = 1'b0;

  pin_report_t line_due_q[$];
  typed_entry_t typed_q[$];
  plan_row_t plan [PLAN_ROWS];

  int mismatches = 0;
  int results_seen = 0;
  int beats_offered = 0;
  int burst_left = 0;
  int ticks_owed = 0;
  int cycle_count = 0;

  ook_remote_frame_transmitter dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_channel(in_channel),
    .in_on_off(in_on_off),
    .in_dim_level(in_dim_level),
    .in_bursts(in_bursts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pin_level(out_pin_level),
    .out_busy_res(out_busy_res),
    .out_rejected(out_rejected),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic logic [LOW_W-1:0] low_units(input logic b, input logic h);
    return (b ^ h) ? LOW_LONG : LOW_SHORT;
  endfunction

  function automatic pin_report_t step_line(input beat_t b);
    pin_report_t r;
    logic [FIELD_W-1:0] stop_at;
    r = '0;
    r.pin_level = line_lvl;
    r.busy_res = playing;
    stop_at = dim_sel ? STOP_DIM : STOP_ONOFF;
    case (b.operation)
      OP_TICK: begin
        if (playing) begin
          tick_cnt = tick_cnt + 1'b1;
          if (tick_cnt >= period_q) begin
            tick_cnt = '0;
            if (line_lvl) begin
              line_lvl = 1'b0;
              if (field_pos == FIELD_START) begin
                low_left = LOW_START;
              end else if (field_pos >= stop_at) begin
                low_left = dim_sel ? LOW_STOP_DIM : LOW_STOP;
              end else if (field_pos <= FIELD_HOUSE_L) begin
                low_left = low_units(~house_q[FIELD_HOUSE_L - field_pos], half_sel);
              end else if (field_pos == FIELD_GROUP) begin
                low_left = low_units(1'b0, half_sel);
              end else if (field_pos == FIELD_MARK) begin
                low_left = dim_sel ? LOW_SHORT : low_units(onoff_q, half_sel);
              end else if (field_pos <= FIELD_CHAN_L) begin
                low_left = low_units(~ch_q[FIELD_CHAN_L - field_pos], half_sel);
              end else begin
                low_left = low_units(~dim_q[FIELD_LEVEL_L - field_pos], half_sel);
              end
            end else begin
              low_left = low_left - 1'b1;
              if (low_left == '0) begin
                if (field_pos >= stop_at) begin
                  field_pos = FIELD_START;
                  half_sel = 1'b0;
                  frames_left = frames_left - 1'b1;
                  playing = (frames_left != '0);
                  line_lvl = playing;
                end else begin
                  if (field_pos == FIELD_START || half_sel) begin
                    field_pos = field_pos + 1'b1;
                    half_sel = 1'b0;
                  end else begin
                    half_sel = 1'b1;
                  end
                  line_lvl = 1'b1;
                end
              end
            end
          end
        end
      end
      OP_ONOFF, OP_DIM: begin
        if (playing) begin
          r.rejected = 1'b1;
        end else begin
          dim_sel = (b.operation == OP_DIM);
          ch_q = b.channel;
          onoff_q = b.on_off;
          dim_q = b.dim_level;
          frames_left = b.bursts;
          if (b.bursts != '0) begin
            playing = 1'b1;
            line_lvl = 1'b1;
            tick_cnt = '0;
            low_left = '0;
            field_pos = FIELD_START;
            half_sel = 1'b0;
          end
        end
        r.pin_level = line_lvl;
        r.busy_res = playing;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch_line
    pin_report_t got;
    pin_report_t want;
    typed_entry_t te;
    beat_t b;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_pin_level, out_busy_res, out_rejected};
        results_seen++;
        if (line_due_q.size() == 0) begin
          note_mismatch("unexpected result beat", 32'(got), '0);
        end else begin
          want = line_due_q.pop_front();
          if (got.pin_level !== want.pin_level)
            note_mismatch("pin_level", 32'(got.pin_level), 32'(want.pin_level));
          if (got.busy_res !== want.busy_res)
            note_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
          if (got.rejected !== want.rejected)
            note_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
        end
      end
      if (in_valid && !in_stall) begin
        b = {in_operation, in_channel, in_on_off, in_dim_level, in_bursts};
        te = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
        want = step_line(b);
        line_due_q.push_back(te.typed ? te.want : want);
      end
    end
  end

  initial begin : receiver
    stall_mode_e mode;
    int mode_left;
    int hold_left;
    int pattern_pos;
    logic hold_done;
    logic s;
    mode = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    pattern_pos = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      pattern_pos++;
      if (mode_left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left == 0 && !hold_done && results_seen >= 500) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        s = 1'b1;
      end else begin
        case (mode)
          STALL_NONE: s = 1'b0;
          STALL_LIGHT: s = ($urandom_range(0, 2) == 0);
          STALL_COMB: s = (pattern_pos % 4 == 3);
          default: s = ($urandom_range(0, 2) != 0);
        endcase
      end
      out_stall <= s;
    end
  end

  task automatic offer(input beat_t b, input logic typed, input pin_report_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    typed_q.push_back({typed, want});
    beats_offered++;
    in_valid <= 1'b1;
    in_operation <= b.operation;
    in_channel <= b.channel;
    in_on_off <= b.on_off;
    in_dim_level <= b.dim_level;
    in_bursts <= b.bursts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (line_due_q.size() != 0 || typed_q.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] held;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_HOUSE_CODE) begin
      house_q = value[HOUSE_W-1:0];
      held = 32'(house_q);
    end else begin
      period_q = value[PERIOD_W-1:0];
      held = 32'(period_q);
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== held) note_mismatch("register read-back", prdata, held);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic beat_t random_beat(input logic [1:0] op);
    beat_t b;
    b.operation = op;
    b.channel = NIBBLE_W'($urandom_range(0, 15));
    b.on_off = 1'($urandom_range(0, 1));
    b.dim_level = NIBBLE_W'($urandom_range(0, 15));
    b.bursts = NIBBLE_W'($urandom_range(0, 15));
    return b;
  endfunction

  function automatic int frame_ticks(input logic dim, input logic [NIBBLE_W-1:0] b);
    int eff;
    eff = (period_q == '0) ? 1 : int'(period_q);
    return int'(b) * (dim ? FRAME_UNITS_DIM : FRAME_UNITS_ONOFF) * eff;
  endfunction

  // A command followed by enough ticks to play its frames out, now and then cut
  // short so that the next command arrives while frames are still playing.
  task automatic play_sequence();
    beat_t b;
    int n;
    int r;
    b = random_beat($urandom_range(0, 1) ? OP_DIM : OP_ONOFF);
    r = $urandom_range(0, 9);
    b.bursts = (r == 0) ? 4'd0 : (r == 9) ? 4'd2 : 4'd1;
    offer(b, 1'b0, '0);
    if (ticks_owed == 0) ticks_owed = frame_ticks(b.operation == OP_DIM, b.bursts);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ticks_owed)
                                     : ticks_owed + $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (beats_offered >= RANDOM_TARGET) break;
      if ($urandom_range(0, 24) == 0) begin
        b = random_beat(OP_NONE);
        if (ticks_owed > 0 && $urandom_range(0, 1))
          b.operation = $urandom_range(0, 1) ? OP_DIM : OP_ONOFF;
        offer(b, 1'b0, '0);
      end
      offer(random_beat(OP_TICK), 1'b0, '0);
      if (ticks_owed > 0) ticks_owed--;
    end
  endtask

  function automatic plan_row_t beat_row(input logic [1:0] op, input logic [3:0] ch,
                                         input logic oo, input logic [3:0] dim,
                                         input logic [3:0] b, input logic typed,
                                         input pin_report_t want);
    plan_row_t row;
    row = '0;
    row.kind = ROW_BEAT;
    row.beat = {op, ch, oo, dim, b};
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic idx, input logic [31:0] value);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.value = value;
    return row;
  endfunction

  initial begin : stimulus
    logic [31:0] house;
    logic [31:0] period;
    int phase;
    plan = '{
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b1, 3'b000),
      beat_row(OP_NONE, 4'd0, 1'b0, 4'd0, 4'd0, 1'b1, 3'b000),
      beat_row(OP_ONOFF, 4'd0, 1'b0, 4'd0, 4'd0, 1'b1, 3'b000),
      beat_row(OP_TICK, 4'd15, 1'b1, 4'd15, 4'd15, 1'b1, 3'b000),
      beat_row(OP_ONOFF, 4'd15, 1'b1, 4'd15, 4'd0, 1'b1, 3'b000),
      beat_row(OP_DIM, 4'd15, 1'b1, 4'd15, 4'd1, 1'b1, 3'b110),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b1, 3'b110),
      beat_row(OP_ONOFF, 4'd5, 1'b1, 4'd10, 4'd15, 1'b1, 3'b111),
      beat_row(OP_DIM, 4'd10, 1'b0, 4'd5, 4'd15, 1'b1, 3'b111),
      beat_row(OP_NONE, 4'd15, 1'b1, 4'd15, 4'd15, 1'b1, 3'b110),
      reg_row(REG_UNIT_PERIOD, 32'd1023),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd9, 1'b1, 4'd6, 4'd3, 1'b0, '0),
      reg_row(REG_UNIT_PERIOD, 32'd0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      reg_row(REG_HOUSE_CODE, 32'h03FF_FFFF),
      reg_row(REG_UNIT_PERIOD, 32'd1),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0),
      beat_row(OP_TICK, 4'd0, 1'b0, 4'd0, 4'd0, 1'b0, '0)
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        offer(plan[i].beat, plan[i].typed, plan[i].want);
      end
    end

    // The dim frame started above is still playing out.
    ticks_owed = FRAME_UNITS_DIM;
    phase = 0;
    while (beats_offered < RANDOM_TARGET) begin
      settle();
      case (phase % 4)
        0: begin
          house = 32'(HOUSE_CODE_RST);
          period = 32'd1;
        end
        1: begin
          house = '0;
          period = 32'd2;
        end
        2: begin
          house = 32'h03FF_FFFF;
          period = 32'd1;
        end
        default: begin
          house = $urandom;
          period = $urandom_range(1, 3);
        end
      endcase
      write_reg(REG_HOUSE_CODE, house);
      write_reg(REG_UNIT_PERIOD, period);
      play_sequence();
      if ($urandom_range(0, 2) == 0) play_sequence();
      phase++;
    end

    settle();
    repeat (END_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
